// File: rtl/core/consensus_alert_fsm_defines.svh
// ----------------------------------------------------------------------------
// consensus_alert_fsm_defines
// assertion macros shared by the alarm qualifier rtl
// ----------------------------------------------------------------------------
`ifndef CONSENSUS_ALERT_FSM_DEFINES_SVH
`define CONSENSUS_ALERT_FSM_DEFINES_SVH

// checked on every rising edge outside reset
`define CAFSM_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// checked on every rising edge, reset included
`define CAFSM_ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

// File: rtl/core/cafsm_pkg.sv
// ----------------------------------------------------------------------------
// cafsm_pkg
// types and constants of the consensus alarm qualifier
// ----------------------------------------------------------------------------
package cafsm_pkg;

  localparam int ADDR_BITS = 4;
  localparam int DATA_BITS = 32;
  localparam int COUNT_BITS = 16;
  localparam int PERMILLE_BITS = 10;

  // mode codes
  localparam logic [1:0] MODE_IDLE    = 2'd0;
  localparam logic [1:0] MODE_PENDING = 2'd1;
  localparam logic [1:0] MODE_ALERT   = 2'd2;

  // register indexes (word address)
  localparam logic [1:0] REG_TIMEOUT   = 2'd0;
  localparam logic [1:0] REG_HOLD      = 2'd1;
  localparam logic [1:0] REG_THRESHOLD = 2'd2;

  localparam logic [COUNT_BITS-1:0]    TIMEOUT_RESET   = 16'd5;
  localparam logic [COUNT_BITS-1:0]    HOLD_RESET      = 16'd60;
  localparam logic [PERMILLE_BITS-1:0] THRESHOLD_RESET = 10'd600;
  localparam logic [PERMILLE_BITS-1:0] VOTE_SCALE      = 10'd1000;

  typedef struct packed {
    logic [COUNT_BITS-1:0]    timeout;
    logic [COUNT_BITS-1:0]    hold;
    logic [PERMILLE_BITS-1:0] threshold;
  } cfg_t;

  typedef struct packed {
    logic [1:0] mode;
    logic       send;
    logic       flag;
    logic       voted;
    logic       pulse;
  } step_res_t;

endpackage

// File: rtl/core/cafsm_cfg.sv
// ----------------------------------------------------------------------------
// cafsm_cfg
// apb register file: consensus timeout, alert hold and vote threshold
// ----------------------------------------------------------------------------
module cafsm_cfg (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            psel,
  input  logic                            penable,
  input  logic                            pwrite,
  input  logic [cafsm_pkg::ADDR_BITS-1:0] paddr,
  input  logic [cafsm_pkg::DATA_BITS-1:0] pwdata,
  output logic [cafsm_pkg::DATA_BITS-1:0] prdata,
  output logic                            pready,
  output cafsm_pkg::cfg_t                 cfg
);

  logic       wr_en;
  logic [1:0] reg_idx;

  assign pready  = 1'b1;
  assign reg_idx = paddr[3:2];
  assign wr_en   = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.timeout   <= cafsm_pkg::TIMEOUT_RESET;
      cfg.hold      <= cafsm_pkg::HOLD_RESET;
      cfg.threshold <= cafsm_pkg::THRESHOLD_RESET;
    end else if (wr_en) begin
      unique case (reg_idx)
        cafsm_pkg::REG_TIMEOUT:   cfg.timeout   <= pwdata[cafsm_pkg::COUNT_BITS-1:0];
        cafsm_pkg::REG_HOLD:      cfg.hold      <= pwdata[cafsm_pkg::COUNT_BITS-1:0];
        cafsm_pkg::REG_THRESHOLD: cfg.threshold <= pwdata[cafsm_pkg::PERMILLE_BITS-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (reg_idx)
      cafsm_pkg::REG_TIMEOUT:   prdata = cafsm_pkg::DATA_BITS'(cfg.timeout);
      cafsm_pkg::REG_HOLD:      prdata = cafsm_pkg::DATA_BITS'(cfg.hold);
      cafsm_pkg::REG_THRESHOLD: prdata = cafsm_pkg::DATA_BITS'(cfg.threshold);
      default:                  prdata = '0;
    endcase
  end

endmodule

// File: rtl/core/cafsm_step.sv
// ----------------------------------------------------------------------------
// cafsm_step
// transition logic for one status word: tick count, vote and next mode
// ----------------------------------------------------------------------------
module cafsm_step #(
  parameter int PEER_COUNT_BITS = 8
) (
  input  cafsm_pkg::cfg_t                  cfg,
  input  logic [1:0]                       mode_cur,
  input  logic [cafsm_pkg::COUNT_BITS-1:0] count_cur,
  input  logic                             local_hit,
  input  logic                             tick,
  input  logic [PEER_COUNT_BITS-1:0]       active_peers,
  input  logic [PEER_COUNT_BITS-1:0]       detecting_peers,
  output logic [1:0]                       mode_next,
  output logic [cafsm_pkg::COUNT_BITS-1:0] count_next,
  output cafsm_pkg::step_res_t             res
);

  localparam int TOTAL_W = PEER_COUNT_BITS + 1;
  localparam int PROD_W  = TOTAL_W + cafsm_pkg::PERMILLE_BITS;

  logic [TOTAL_W-1:0] total;
  logic [TOTAL_W-1:0] yes;
  logic [PROD_W-1:0]  lhs;
  logic [PROD_W-1:0]  rhs;
  logic               vote_pass;
  logic [1:0]         mode_in;
  logic [cafsm_pkg::COUNT_BITS-1:0] count_tick;

  // self is counted on both sides
  assign total = TOTAL_W'(active_peers) + TOTAL_W'(1);
  assign yes   = TOTAL_W'(detecting_peers) + TOTAL_W'(1);
  assign lhs   = PROD_W'(yes) * PROD_W'(cafsm_pkg::VOTE_SCALE);
  assign rhs   = PROD_W'(cfg.threshold) * PROD_W'(total);
  assign vote_pass = (lhs >= rhs);

  // the unused code falls back to idle
  assign mode_in = (mode_cur == cafsm_pkg::MODE_PENDING ||
                    mode_cur == cafsm_pkg::MODE_ALERT) ? mode_cur : cafsm_pkg::MODE_IDLE;
  assign count_tick = (tick && count_cur != '1) ?
                      count_cur + cafsm_pkg::COUNT_BITS'(1) : count_cur;

  always_comb begin
    mode_next  = mode_in;
    count_next = count_tick;
    res        = '0;
    if (local_hit) begin
      if (mode_next == cafsm_pkg::MODE_IDLE) begin
        mode_next  = cafsm_pkg::MODE_PENDING;
        count_next = '0;
        res.send   = 1'b1;
        res.flag   = 1'b1;
      end
      // a zero timeout votes in the same word that enters pending
      if (mode_next == cafsm_pkg::MODE_PENDING && count_next >= cfg.timeout) begin
        res.voted  = 1'b1;
        count_next = '0;
        if (vote_pass) begin
          mode_next = cafsm_pkg::MODE_ALERT;
          res.pulse = 1'b1;
        end else begin
          mode_next = cafsm_pkg::MODE_IDLE;
        end
      end
    end else begin
      if (mode_next == cafsm_pkg::MODE_ALERT) begin
        if (count_next >= cfg.hold) begin
          mode_next  = cafsm_pkg::MODE_IDLE;
          count_next = '0;
          res.send   = 1'b1;
        end
      end else if (mode_next == cafsm_pkg::MODE_PENDING) begin
        mode_next  = cafsm_pkg::MODE_IDLE;
        count_next = '0;
        res.send   = 1'b1;
      end
    end
    res.mode = mode_next;
  end

endmodule

// File: rtl/core/consensus_alert_fsm.sv
// ----------------------------------------------------------------------------
// consensus_alert_fsm
// three-mode alarm qualifier (idle, pending, alert) with peer consensus vote
//
//   channel  handshake            payload
//   -------  -------------------  ------------------------------------------
//   in       in_valid / in_stall  sensor_hit vision_hit active_peers
//                                 detecting_peers second_tick
//   out      out_valid/out_stall  mode send_broadcast broadcast_flag
//                                 vote_done alarm_pulse
//   cfg      apb (psel/penable)   timeout, hold, threshold registers
//
// one word per cycle while the result register is not stalled; a word passes
// the input register, then the transition logic into the result register and mode/count state
// the mode and seconds count update in the same cycle as the result
// register, so the next word always sees the state left by this one
// out_stall holds the result register; in_stall rises only once the input
// register is also full, so one word can wait behind a stalled result
// synchronous reset returns idle, a zero count and the register defaults
// ----------------------------------------------------------------------------
`include "consensus_alert_fsm_defines.svh"

module consensus_alert_fsm #(
  parameter int PEER_COUNT_BITS = 8
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            psel,
  input  logic                            penable,
  input  logic                            pwrite,
  input  logic [cafsm_pkg::ADDR_BITS-1:0] paddr,
  input  logic [cafsm_pkg::DATA_BITS-1:0] pwdata,
  output logic [cafsm_pkg::DATA_BITS-1:0] prdata,
  output logic                            pready,
  input  logic                            in_valid,
  output logic                            in_stall,
  input  logic                            sensor_hit,
  input  logic                            vision_hit,
  input  logic [PEER_COUNT_BITS-1:0]      active_peers,
  input  logic [PEER_COUNT_BITS-1:0]      detecting_peers,
  input  logic                            second_tick,
  output logic                            out_valid,
  input  logic                            out_stall,
  output logic [1:0]                      mode,
  output logic                            send_broadcast,
  output logic                            broadcast_flag,
  output logic                            vote_done,
  output logic                            alarm_pulse
);

  cafsm_pkg::cfg_t      cfg;
  cafsm_pkg::step_res_t res;

  logic                       s1_valid;
  logic                       s1_local;
  logic                       s1_tick;
  logic [PEER_COUNT_BITS-1:0] s1_active;
  logic [PEER_COUNT_BITS-1:0] s1_detecting;

  logic [1:0]                       mode_reg;
  logic [1:0]                       mode_next;
  logic [cafsm_pkg::COUNT_BITS-1:0] seconds_count;
  logic [cafsm_pkg::COUNT_BITS-1:0] seconds_count_next;

  logic out_free;
  logic s1_fire;

  assign out_free = !out_valid || !out_stall;
  assign s1_fire  = s1_valid && out_free;
  assign in_stall = s1_valid && !out_free;

  cafsm_cfg u_cfg (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  cafsm_step #(
    .PEER_COUNT_BITS (PEER_COUNT_BITS)
  ) u_step (
    .cfg             (cfg),
    .mode_cur        (mode_reg),
    .count_cur       (seconds_count),
    .local_hit       (s1_local),
    .tick            (s1_tick),
    .active_peers    (s1_active),
    .detecting_peers (s1_detecting),
    .mode_next       (mode_next),
    .count_next      (seconds_count_next),
    .res             (res)
  );

  // input register
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (!in_stall) begin
      s1_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      s1_local     <= sensor_hit || vision_hit;
      s1_tick      <= second_tick;
      s1_active    <= active_peers;
      s1_detecting <= detecting_peers;
    end
  end

  // mode and seconds state
  always_ff @(posedge clk) begin
    if (rst) begin
      mode_reg      <= cafsm_pkg::MODE_IDLE;
      seconds_count <= '0;
    end else if (s1_fire) begin
      mode_reg      <= mode_next;
      seconds_count <= seconds_count_next;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_free) begin
      out_valid <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_fire) begin
      mode           <= res.mode;
      send_broadcast <= res.send;
      broadcast_flag <= res.flag;
      vote_done      <= res.voted;
      alarm_pulse    <= res.pulse;
    end
  end

  `CAFSM_ASSERT(a_pulse_enters_alert,
    out_valid && alarm_pulse |-> vote_done && mode == cafsm_pkg::MODE_ALERT,
    "alarm pulse without a passed vote")
  `CAFSM_ASSERT(a_word_reaches_output, s1_fire |=> out_valid,
    "accepted word did not reach the result register")
  `CAFSM_ASSERT(a_count_cleared_on_entry, s1_fire && mode_next != mode_reg |=> seconds_count == '0,
    "seconds count not cleared on mode entry")
  `CAFSM_ASSERT_ALWAYS(a_stall_only_when_full, in_stall |-> s1_valid,
    "input stalled with an empty input register")

endmodule
